// ===== rtl/core/ifsr_pkg.sv =====
// Shared types and constants for the interrupt frame stack register block.
// No dependencies; imported by ifsr_ctrl, ifsr_datapath and the top level.
package ifsr_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_RESPOND
    } state_t;

    // read-data source picked during decode
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_STACK,
        SRC_TRAMP,
        SRC_VEC,
        SRC_MASK,
        SRC_STATUS,
        SRC_RETURN
    } src_t;

    typedef struct packed {
        logic clear;     // memory clearing sweep step
        logic capture;   // latch a new access
        logic access;    // decode, read memories, perform writes
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_stat_t;

    localparam logic [1:0] FUNC_IFETCH = 2'd0;
    localparam logic [1:0] FUNC_DREAD  = 2'd1;
    localparam logic [1:0] FUNC_WRITE  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

    localparam logic [11:0] REG_MASK   = 12'hffd;
    localparam logic [11:0] REG_STATUS = 12'hffe;
    localparam logic [11:0] REG_RETURN = 12'hfff;

    localparam logic [1:0] CFG_STACK_TOP  = 2'd0;
    localparam logic [1:0] CFG_TRAMP_BASE = 2'd1;
    localparam logic [1:0] CFG_VEC_BASE   = 2'd2;

    localparam logic [31:0] STACK_TOP_RST  = 32'd2047;
    localparam logic [31:0] TRAMP_BASE_RST = 32'd256;
    localparam logic [31:0] VEC_BASE_RST   = 32'd0;

endpackage

// ===== rtl/core/interrupt_frame_stack_regs_unit.sv =====
// Top level of the interrupt frame stack register block.
// Depends on ifsr_pkg, ifsr_ctrl and ifsr_datapath.
//
//  channel   handshake         payload
//  -------   ---------------   ---------------------------
//  access    start / busy      func, addr, wdata
//  result    done (strobe)     rdata, read_hit, status
//  config    cfg_we            cfg_index, cfg_wdata
//
// An access passes through ST_ACCESS, which decodes and reads the memories through
// their registered read ports, then ST_RESPOND, which presents the result. The next
// start is taken in the result cycle, so a new access is accepted as a result goes out.
// After reset a clearing sweep zeroes all memories, one entry per cycle, over
// max(FRAMES*STACK_WORDS, TRAMP_WORDS, VEC_WORDS, FRAMES) entries (1024 by
// default); busy stays high meanwhile, config writes are still taken.
// done is high for one cycle per result; the receiver cannot stall it.
module interrupt_frame_stack_regs_unit #(
    parameter int FRAMES      = 32,
    parameter int STACK_WORDS = 32,
    parameter int VEC_WORDS   = 32,
    parameter int TRAMP_WORDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] addr,
    input  logic [31:0] wdata,
    output logic        done,
    output logic [31:0] rdata,
    output logic        read_hit,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import ifsr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ifsr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ifsr_datapath #(
        .FRAMES      (FRAMES),
        .STACK_WORDS (STACK_WORDS),
        .VEC_WORDS   (VEC_WORDS),
        .TRAMP_WORDS (TRAMP_WORDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .func      (func),
        .addr      (addr),
        .wdata     (wdata),
        .rdata     (rdata),
        .read_hit  (read_hit),
        .status    (status)
    );

endmodule

// ===== rtl/core/ifsr_ctrl.sv =====
// Sequencer for the interrupt frame stack register block.
// Depends on ifsr_pkg; drives ifsr_datapath through dp_cmd_t.
module ifsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ifsr_pkg::dp_stat_t stat,
    output ifsr_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import ifsr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.clear   = 1'b0;
        cmd.capture = 1'b0;
        cmd.access  = 1'b0;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                // result goes out while the next access may already be taken
                busy = 1'b0;
                done = 1'b1;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACCESS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/core/ifsr_datapath.sv =====
// Datapath: window decode, frame stack and table memories, frame registers.
// Depends on ifsr_pkg; sequenced by ifsr_ctrl.
module ifsr_datapath #(
    parameter int FRAMES      = 32,
    parameter int STACK_WORDS = 32,
    parameter int VEC_WORDS   = 32,
    parameter int TRAMP_WORDS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ifsr_pkg::dp_cmd_t  cmd,
    output ifsr_pkg::dp_stat_t stat,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic [1:0]         func,
    input  logic [31:0]        addr,
    input  logic [31:0]        wdata,
    output logic [31:0]        rdata,
    output logic               read_hit,
    output logic [1:0]         status
);
    import ifsr_pkg::*;

    localparam int SDEPTH  = FRAMES * STACK_WORDS;
    localparam int FRAME_W = $clog2(FRAMES);
    localparam int S_W     = (STACK_WORDS > 1) ? $clog2(STACK_WORDS) : 1;
    localparam int SA_W    = $clog2(SDEPTH);
    localparam int T_W     = (TRAMP_WORDS > 1) ? $clog2(TRAMP_WORDS) : 1;
    localparam int V_W     = (VEC_WORDS > 1) ? $clog2(VEC_WORDS) : 1;
    localparam int LEN_A   = (SDEPTH > TRAMP_WORDS) ? SDEPTH : TRAMP_WORDS;
    localparam int LEN_B   = (VEC_WORDS > FRAMES) ? VEC_WORDS : FRAMES;
    localparam int CLEAR_LEN = (LEN_A > LEN_B) ? LEN_A : LEN_B;
    localparam int CLR_W   = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;

    // configuration
    logic [31:0] stack_top_reg;
    logic [31:0] tramp_base_reg;
    logic [31:0] vec_base_reg;

    // latched access
    logic [1:0]  func_reg;
    logic [31:0] addr_reg;
    logic [31:0] wdata_reg;

    logic [FRAME_W-1:0] depth_reg;
    logic [FRAME_W-1:0] depth_next;
    logic [31:0]        irq_reg;
    logic [CLR_W-1:0]   clr_cnt_reg;
    src_t               src_reg;
    src_t               src_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;

    // memories and their registered read data
    logic [31:0] stack_mem [SDEPTH];
    logic [31:0] tramp_mem [TRAMP_WORDS];
    logic [31:0] vec_mem   [VEC_WORDS];
    logic [31:0] mask_mem  [FRAMES];
    logic [31:0] ret_mem   [FRAMES];
    logic [31:0] stack_q, tramp_q, vec_q, mask_q, ret_q;

    // decode
    logic [31:0]        soff, toff, voff;
    logic               s_hit, t_hit, v_hit;
    logic [11:0]        reg_off;
    logic               is_read, is_write, is_dread;
    logic               push, pop;
    logic [FRAME_W-1:0] pop_idx;
    logic [SA_W-1:0]    s_idx;
    logic               depth_last;

    // memory write ports
    logic               stack_we, tramp_we, vec_we, mask_we, ret_we;
    logic [SA_W-1:0]    stack_widx;
    logic [T_W-1:0]     tramp_widx;
    logic [V_W-1:0]     vec_widx;
    logic [FRAME_W-1:0] frame_widx;
    logic [31:0]        mem_wdat;

    assign soff    = stack_top_reg - addr_reg;
    assign toff    = addr_reg - tramp_base_reg;
    assign voff    = addr_reg - vec_base_reg;
    assign s_hit   = soff < 32'(STACK_WORDS);
    assign t_hit   = toff < 32'(TRAMP_WORDS);
    assign v_hit   = voff < 32'(VEC_WORDS);
    assign reg_off = addr_reg[11:0];

    assign is_dread = func_reg == FUNC_DREAD;
    assign is_read  = (func_reg == FUNC_IFETCH) || is_dread;
    assign is_write = func_reg == FUNC_WRITE;
    assign push     = is_write && (reg_off == REG_RETURN);
    assign pop      = is_dread && (reg_off == REG_RETURN);

    assign depth_last = depth_reg == FRAME_W'(FRAMES - 1);
    assign pop_idx    = (depth_reg == '0) ? '0 : depth_reg - 1'b1;
    assign s_idx      = SA_W'(depth_reg) * SA_W'(STACK_WORDS) + SA_W'(soff[S_W-1:0]);

    assign stat.clear_last = clr_cnt_reg == CLR_W'(CLEAR_LEN - 1);

    always_comb
    begin
        src_next    = SRC_NONE;
        status_next = STATUS_OK;
        depth_next  = depth_reg;
        if (is_read)
        begin
            if (s_hit)
            begin
                src_next = SRC_STACK;
            end
            else if (t_hit)
            begin
                src_next = SRC_TRAMP;
            end
            else if (v_hit)
            begin
                src_next = SRC_VEC;
            end
        end
        if (is_dread)
        begin
            case (reg_off)
                REG_MASK:   src_next = SRC_MASK;
                REG_STATUS: src_next = SRC_STATUS;
                REG_RETURN: src_next = SRC_RETURN;
                default:    ;
            endcase
        end
        if (pop)
        begin
            depth_next = pop_idx;
            if (depth_reg == '0)
            begin
                status_next = STATUS_POP_EMPTY;
            end
        end
        if (push)
        begin
            if (depth_last)
            begin
                status_next = STATUS_PUSH_FULL;
            end
            else
            begin
                depth_next = depth_reg + 1'b1;
            end
        end
    end

    // write ports: clearing sweep or access
    always_comb
    begin
        mem_wdat   = cmd.clear ? '0 : wdata_reg;
        stack_widx = cmd.clear ? clr_cnt_reg[SA_W-1:0] : s_idx;
        tramp_widx = cmd.clear ? clr_cnt_reg[T_W-1:0] : toff[T_W-1:0];
        vec_widx   = cmd.clear ? clr_cnt_reg[V_W-1:0] : voff[V_W-1:0];
        frame_widx = cmd.clear ? clr_cnt_reg[FRAME_W-1:0] : depth_reg;
        if (cmd.clear)
        begin
            stack_we = 32'(clr_cnt_reg) < 32'(SDEPTH);
            tramp_we = 32'(clr_cnt_reg) < 32'(TRAMP_WORDS);
            vec_we   = 32'(clr_cnt_reg) < 32'(VEC_WORDS);
            mask_we  = 32'(clr_cnt_reg) < 32'(FRAMES);
            ret_we   = 32'(clr_cnt_reg) < 32'(FRAMES);
        end
        else
        begin
            stack_we = cmd.access && is_write && s_hit;
            tramp_we = cmd.access && is_write && !s_hit && t_hit;
            vec_we   = cmd.access && is_write && !s_hit && !t_hit && v_hit;
            mask_we  = cmd.access && is_write && (reg_off == REG_MASK);
            ret_we   = cmd.access && push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_widx] <= mem_wdat;
        end
        if (cmd.access)
        begin
            stack_q <= stack_mem[s_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tramp_we)
        begin
            tramp_mem[tramp_widx] <= mem_wdat;
        end
        if (cmd.access)
        begin
            tramp_q <= tramp_mem[toff[T_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vec_we)
        begin
            vec_mem[vec_widx] <= mem_wdat;
        end
        if (cmd.access)
        begin
            vec_q <= vec_mem[voff[V_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[frame_widx] <= mem_wdat;
        end
        if (cmd.access)
        begin
            mask_q <= mask_mem[depth_reg];
        end
    end

    // pop returns the word of the frame it reveals
    always_ff @(posedge clk)
    begin
        if (ret_we)
        begin
            ret_mem[frame_widx] <= mem_wdat;
        end
        if (cmd.access)
        begin
            ret_q <= ret_mem[pop_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            addr_reg  <= addr;
            wdata_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_top_reg  <= STACK_TOP_RST;
            tramp_base_reg <= TRAMP_BASE_RST;
            vec_base_reg   <= VEC_BASE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STACK_TOP:  stack_top_reg  <= cfg_wdata;
                CFG_TRAMP_BASE: tramp_base_reg <= cfg_wdata;
                CFG_VEC_BASE:   vec_base_reg   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= '0;
            irq_reg     <= '0;
            clr_cnt_reg <= '0;
            src_reg     <= SRC_NONE;
            status_reg  <= STATUS_OK;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.access)
            begin
                depth_reg  <= depth_next;
                src_reg    <= src_next;
                status_reg <= status_next;
                if (is_write && (reg_off == REG_STATUS))
                begin
                    irq_reg <= wdata_reg;
                end
            end
        end
    end

    always_comb
    begin
        case (src_reg)
            SRC_STACK:  rdata = stack_q;
            SRC_TRAMP:  rdata = tramp_q;
            SRC_VEC:    rdata = vec_q;
            SRC_MASK:   rdata = mask_q;
            SRC_STATUS: rdata = irq_reg;
            SRC_RETURN: rdata = ret_q;
            default:    rdata = '0;
        endcase
    end

    assign read_hit = src_reg != SRC_NONE;
    assign status   = status_reg;

endmodule

// ===== tb/sv/interrupt_frame_stack_regs_unit_tb.sv =====
// Self-checking testbench for interrupt_frame_stack_regs_unit: queued access driver,
// result monitor and an in-bench predictor of the frame stack, tables and registers.
// Depends on ifsr_pkg and the interrupt_frame_stack_regs_unit RTL.
module interrupt_frame_stack_regs_unit_tb;
    import ifsr_pkg::*;

    localparam int FRAMES      = 32;
    localparam int STACK_WORDS = 32;
    localparam int VEC_WORDS   = 32;
    localparam int TRAMP_WORDS = 256;

    // access kind the block ignores
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] addr;
        logic [31:0] wdata;
    } access_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        read_hit;
        logic [1:0]  status;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  func = FUNC_IFETCH;
    logic [31:0] addr = '0;
    logic [31:0] wdata = '0;
    logic        done;
    logic [31:0] rdata;
    logic        read_hit;
    logic [1:0]  status;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_STACK_TOP;
    logic [31:0] cfg_wdata = '0;

    interrupt_frame_stack_regs_unit #(
        .FRAMES      (FRAMES),
        .STACK_WORDS (STACK_WORDS),
        .VEC_WORDS   (VEC_WORDS),
        .TRAMP_WORDS (TRAMP_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .addr      (addr),
        .wdata     (wdata),
        .done      (done),
        .rdata     (rdata),
        .read_hit  (read_hit),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the address map and the block's stores
    logic [31:0] top_addr   = STACK_TOP_RST;
    logic [31:0] tramp_base = TRAMP_BASE_RST;
    logic [31:0] vec_base   = VEC_BASE_RST;
    bit [31:0]   stack_mem [FRAMES*STACK_WORDS];
    bit [31:0]   mask_mem  [FRAMES];
    bit [31:0]   ret_mem   [FRAMES];
    bit [31:0]   vec_mem   [VEC_WORDS];
    bit [31:0]   tramp_mem [TRAMP_WORDS];
    bit [31:0]   irq_word;
    int          frame_ptr;

    access_t access_queue[$];
    result_t predicted_results[$];
    access_t held;
    result_t oldest;
    int      queued;
    int      accepted;
    int      checked;
    int      mismatch_count;
    int      write_count;
    int      push_full_count;
    int      pop_empty_count;
    int      gap_left;
    int      burst_left;
    int      map_count = 1;

    function automatic result_t predict_access(input access_t a);
        result_t     r;
        logic [31:0] soff;
        logic [31:0] toff;
        logic [31:0] voff;
        logic [11:0] sel;
        int          cur;
        r    = '0;
        cur  = frame_ptr;
        soff = top_addr - a.addr;
        toff = a.addr - tramp_base;
        voff = a.addr - vec_base;
        sel  = a.addr[11:0];
        if (a.func == FUNC_IFETCH || a.func == FUNC_DREAD)
        begin
            // stack window has priority, then trampolines, then vectors
            if (soff < STACK_WORDS)
            begin
                r.rdata    = stack_mem[cur*STACK_WORDS + int'(soff)];
                r.read_hit = 1'b1;
            end
            else if (toff < TRAMP_WORDS)
            begin
                r.rdata    = tramp_mem[toff];
                r.read_hit = 1'b1;
            end
            else if (voff < VEC_WORDS)
            begin
                r.rdata    = vec_mem[voff];
                r.read_hit = 1'b1;
            end
            if (a.func == FUNC_DREAD)
            begin
                if (sel == REG_MASK)
                begin
                    r.rdata    = mask_mem[cur];
                    r.read_hit = 1'b1;
                end
                else if (sel == REG_STATUS)
                begin
                    r.rdata    = irq_word;
                    r.read_hit = 1'b1;
                end
                else if (sel == REG_RETURN)
                begin
                    // pop returns the word of the frame it uncovers
                    if (cur == 0)
                    begin
                        r.status = STATUS_POP_EMPTY;
                        pop_empty_count++;
                    end
                    else
                        cur--;
                    frame_ptr  = cur;
                    r.rdata    = ret_mem[cur];
                    r.read_hit = 1'b1;
                end
            end
        end
        else if (a.func == FUNC_WRITE)
        begin
            write_count++;
            if (soff < STACK_WORDS)
                stack_mem[cur*STACK_WORDS + int'(soff)] = a.wdata;
            else if (toff < TRAMP_WORDS)
                tramp_mem[toff] = a.wdata;
            else if (voff < VEC_WORDS)
                vec_mem[voff] = a.wdata;
            if (sel == REG_MASK)
                mask_mem[cur] = a.wdata;
            else if (sel == REG_STATUS)
                irq_word = a.wdata;
            else if (sel == REG_RETURN)
            begin
                ret_mem[cur] = a.wdata;
                if (cur >= FRAMES - 1)
                begin
                    r.status = STATUS_PUSH_FULL;
                    push_full_count++;
                end
                else
                    cur++;
                frame_ptr = cur;
            end
        end
        return r;
    endfunction

    // driver: bursts of back-to-back transfers separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n && !(start && busy))
        begin
            if (start)
            begin
                predicted_results.push_back(predict_access(held));
                accepted++;
            end
            if (gap_left > 0 || access_queue.size() == 0)
            begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                held = access_queue.pop_front();
                func  <= held.func;
                addr  <= held.addr;
                wdata <= held.wdata;
                start <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
        end
    end

    // monitor: results cannot be stalled, check each strobe against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: rdata %h hit %b status %0d",
                             rdata, read_hit, status);
            end
            else
            begin
                oldest = predicted_results.pop_front();
                checked++;
                if (rdata !== oldest.rdata || read_hit !== oldest.read_hit ||
                    status !== oldest.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d: expected rdata %h hit %b status %0d,",
                                  " got rdata %h hit %b status %0d"},
                                 checked, oldest.rdata, oldest.read_hit, oldest.status,
                                 rdata, read_hit, status);
                end
            end
        end
    end

    task automatic add_access(input logic [1:0] f, input logic [31:0] a, input logic [31:0] d);
        access_t t;
        t.func  = f;
        t.addr  = a;
        t.wdata = d;
        access_queue.push_back(t);
        queued++;
    endtask

    function automatic logic [31:0] reg_addr(input logic [11:0] sel);
        logic [31:0] r;
        r = $urandom;
        return {r[31:12], sel};
    endfunction

    function automatic logic [31:0] stack_slot_addr();
        return top_addr - $urandom_range(0, STACK_WORDS - 1);
    endfunction

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 6))
            0: return stack_slot_addr();
            1: return tramp_base + $urandom_range(0, TRAMP_WORDS - 1);
            2: return vec_base + $urandom_range(0, VEC_WORDS - 1);
            3: return reg_addr(REG_MASK + 12'($urandom_range(0, 2)));
            4:
            begin
                // one step outside a window
                case ($urandom_range(0, 5))
                    0: return top_addr - STACK_WORDS;
                    1: return top_addr + 1;
                    2: return tramp_base - 1;
                    3: return tramp_base + TRAMP_WORDS;
                    4: return vec_base - 1;
                    default: return vec_base + VEC_WORDS;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_func();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return FUNC_WRITE;
        else if (r < 14)
            return FUNC_DREAD;
        else if (r < 19)
            return FUNC_IFETCH;
        return FUNC_NONE;
    endfunction

    task automatic add_noise(input int n);
        repeat (n)
            add_access(pick_func(), pick_addr(), $urandom);
    endtask

    // interrupt nesting: set up and push frames, then unwind and read them back
    task automatic add_nest(input int levels, input bit rich);
        repeat (levels)
        begin
            if (rich)
            begin
                add_access(FUNC_WRITE, reg_addr(REG_MASK), $urandom);
                repeat ($urandom_range(1, 2))
                    add_access(FUNC_WRITE, stack_slot_addr(), $urandom);
                if ($urandom_range(0, 3) == 0)
                    add_noise(1);
            end
            add_access(FUNC_WRITE, reg_addr(REG_RETURN), $urandom);
        end
        repeat (levels)
        begin
            add_access(FUNC_DREAD, reg_addr(REG_RETURN), $urandom);
            if (rich)
            begin
                add_access($urandom_range(0, 1) ? FUNC_IFETCH : FUNC_DREAD, stack_slot_addr(),
                           $urandom);
                add_access(FUNC_DREAD, reg_addr(REG_MASK), $urandom);
                if ($urandom_range(0, 3) == 0)
                    add_access(FUNC_DREAD, reg_addr(REG_STATUS), $urandom);
            end
        end
    endtask

    task automatic fill_phase(input int target);
        int first;
        first = queued;
        // one nest deep enough to saturate on push and on pop
        add_nest(FRAMES + 1, 1'b0);
        while (queued - first < target)
        begin
            if ($urandom_range(0, 9) < 7)
                add_nest($urandom_range(1, 8), 1'b1);
            else
                add_noise($urandom_range(6, 15));
        end
    endtask

    task automatic wait_drained();
        while (access_queue.size() != 0 || start || predicted_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_STACK_TOP:  top_addr   = val;
            CFG_TRAMP_BASE: tramp_base = val;
            CFG_VEC_BASE:   vec_base   = val;
            default: ;
        endcase
    endtask

    initial
    begin
        #400000;
        $display("FAIL interrupt_frame_stack_regs_unit");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass on the reset address map
        add_access(FUNC_IFETCH, 32'h0000_07ff, 32'h0);
        add_access(FUNC_WRITE,  32'h0000_07ff, 32'hffff_ffff);
        add_access(FUNC_DREAD,  32'h0000_07ff, 32'h0);
        add_access(FUNC_WRITE,  32'h0000_07e0, 32'h5a5a_5a5a);
        add_access(FUNC_IFETCH, 32'h0000_07e0, 32'h0);
        add_access(FUNC_WRITE,  32'h0000_0100, 32'ha5a5_a5a5);
        add_access(FUNC_DREAD,  32'h0000_01ff, 32'h0);
        add_access(FUNC_IFETCH, 32'h0000_0100, 32'h0);
        add_access(FUNC_WRITE,  32'h0000_001f, 32'h0000_ffff);
        add_access(FUNC_IFETCH, 32'h0000_001f, 32'h0);
        add_access(FUNC_DREAD,  32'h0000_0020, 32'h0);
        add_access(FUNC_DREAD,  {20'h0, REG_RETURN}, 32'h0);
        add_access(FUNC_WRITE,  {20'h0, REG_MASK}, 32'h1234_5678);
        add_access(FUNC_DREAD,  {20'hfffff, REG_MASK}, 32'hffff_ffff);
        add_access(FUNC_WRITE,  {20'h0, REG_STATUS}, 32'hffff_ffff);
        add_access(FUNC_DREAD,  {20'h0, REG_STATUS}, 32'h0);
        // registers are invisible to instruction fetches
        add_access(FUNC_IFETCH, {20'h0, REG_STATUS}, 32'h0);
        add_access(FUNC_WRITE,  {20'h0, REG_RETURN}, 32'hdead_0001);
        add_access(FUNC_WRITE,  32'h0000_07ff, 32'h1111_1111);
        add_access(FUNC_DREAD,  32'h0000_07ff, 32'h0);
        add_access(FUNC_DREAD,  {20'h0, REG_RETURN}, 32'h0);
        add_access(FUNC_DREAD,  32'h0000_07ff, 32'h0);
        add_access(FUNC_NONE,   {20'hfffff, REG_RETURN}, 32'hffff_ffff);
        add_access(FUNC_WRITE,  32'h8000_0000, 32'h0);
        add_access(FUNC_DREAD,  32'hffff_f000, 32'h0);
        fill_phase(160);

        for (int phase = 1; phase < 6; phase++)
        begin
            wait_drained();
            case (phase)
                1:
                begin
                    // all three windows overlap, registers sit inside the stack window
                    write_cfg(CFG_STACK_TOP,  32'h0000_0fff);
                    write_cfg(CFG_TRAMP_BASE, 32'h0000_0ff0);
                    write_cfg(CFG_VEC_BASE,   32'h0000_0fe8);
                end
                2:
                begin
                    // windows wrapping around the address space
                    write_cfg(CFG_STACK_TOP,  32'h0000_0000);
                    write_cfg(CFG_TRAMP_BASE, 32'hffff_ff80);
                    write_cfg(CFG_VEC_BASE,   32'hffff_ffff);
                end
                3:
                begin
                    write_cfg(CFG_STACK_TOP,  32'hffff_ffff);
                    write_cfg(CFG_TRAMP_BASE, 32'h0000_0000);
                    write_cfg(CFG_VEC_BASE,   32'h0000_0000);
                end
                4:
                begin
                    write_cfg(CFG_STACK_TOP,  $urandom);
                    write_cfg(CFG_TRAMP_BASE, 32'hffff_ffff);
                    write_cfg(CFG_VEC_BASE,   $urandom);
                end
                default:
                begin
                    write_cfg(CFG_VEC_BASE,   $urandom);
                    write_cfg(CFG_TRAMP_BASE, $urandom);
                    write_cfg(CFG_STACK_TOP,  $urandom);
                end
            endcase
            @(posedge clk);
            cfg_we <= 1'b0;
            map_count++;
            fill_phase(180);
        end

        wait_drained();
        $display("checked %0d of %0d accesses over %0d address maps: %0d writes",
                 checked, accepted, map_count, write_count);
        $display("saturated pushes %0d, pops at frame zero %0d, mismatches %0d",
                 push_full_count, pop_empty_count, mismatch_count);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("PASS interrupt_frame_stack_regs_unit");
        else
            $display("FAIL interrupt_frame_stack_regs_unit");
        $finish;
    end

endmodule
